// File: hw/rtl/aat_pkg.sv
// Package for the active alarm table: sizes, request and status codes,
// and the packed beat and table entry types. No dependencies.
package aat_pkg;

  localparam int MAX_ACTIVE = 16;
  localparam int CODE_BITS  = 16;
  localparam int RESULT_CAP = 16;

  localparam int LIST_CAP = (MAX_ACTIVE < RESULT_CAP) ? MAX_ACTIVE : RESULT_CAP;
  localparam int CODE_W   = (CODE_BITS < 16) ? CODE_BITS : 16;
  localparam int CNT_W    = $clog2(MAX_ACTIVE + 1);
  localparam int IDX_W    = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int LEN_W    = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [1:0] REQ_RAISE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_LIST  = 2'd2;

  localparam logic [1:0] LVL_CRIT = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_LIST     = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  alarm_level;
    logic [15:0] alarm_code;
    logic [31:0] raise_time;
    logic [4:0]  max_entries;
  } alarm_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [1:0]  entry_level;
    logic [15:0] entry_code;
    logic [31:0] entry_time;
    logic        last;
    logic [4:0]  active_count;
    logic        any_critical;
  } alarm_rsp_t;

  typedef struct packed {
    logic [1:0]        level;
    logic [CODE_W-1:0] code;
    logic [31:0]       stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/aat_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module aat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/active_alarm_table_core.sv
// Active alarm table core: ordered table of alarms held in aat_ram.
// Depends on aat_pkg and aat_ram.
//
// The block keeps up to MAX_ACTIVE alarms (level, code, timestamp) in table
// order in one RAM with a single registered read port, so every table access
// is one entry per cycle. One request is worked at a time. A raise or a clear
// scans the table from the oldest entry, one entry per cycle, until it finds
// the code or reaches the end, then decides in S_DECIDE and presents its
// single result beat from S_EMIT. A clear that hits entry i then moves every
// later entry down by one, one entry per cycle. A list request of n entries
// presents one beat per cycle while the result channel does not stall, after
// the registered read of its first entry; an empty list presents a single
// status beat. A stalled result channel holds the block in place; the next
// request is taken as soon as the last beat of the current one sits in the
// output register, even while that beat still waits. The table needs no
// clearing after reset: only entries below the active count are ever read.
module active_alarm_table_core import aat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  alarm_req_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output alarm_rsp_t out_data
);

  localparam int CW1 = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_EMIT,
    S_LIST
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         req_type_r, req_type_nxt;
  entry_t             new_entry_r, new_entry_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [1:0]         found_lvl_r, found_lvl_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [LEN_W-1:0]   list_n_r, list_n_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   crit_cnt_r, crit_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  alarm_rsp_t         out_data_r, out_data_nxt;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_raw;
  entry_t             ram_rd_data;

  logic               out_free;
  logic [CW1-1:0]     idx_p1, idx_p2, cnt_ext1;
  logic [LEN_W-1:0]   acc_n, len_cnt, len_max;
  logic               list_last;

  aat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ACTIVE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  assign ram_rd_data = entry_t'(ram_rd_raw);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  assign idx_p1   = CW1'(idx_r) + CW1'(1);
  assign idx_p2   = CW1'(idx_r) + CW1'(2);
  assign cnt_ext1 = CW1'(count_r);

  // List length for the request at the port: min(count, max_entries, cap).
  always_comb begin
    len_cnt = LEN_W'(count_r);
    len_max = LEN_W'(in_data.max_entries);
    acc_n   = (len_cnt < len_max) ? len_cnt : len_max;
    if (acc_n > LEN_W'(LIST_CAP)) begin
      acc_n = LEN_W'(LIST_CAP);
    end
  end

  assign list_last = (LEN_W'(idx_p1) == list_n_r);

  always_comb begin
    state_nxt     = state_r;
    req_type_nxt  = req_type_r;
    new_entry_nxt = new_entry_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    found_lvl_nxt = found_lvl_r;
    status_nxt    = status_r;
    list_n_nxt    = list_n_r;
    count_nxt     = count_r;
    crit_cnt_nxt  = crit_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_p1[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt        = in_data.req_type;
          new_entry_nxt.level = in_data.alarm_level;
          new_entry_nxt.code  = CODE_W'(in_data.alarm_code);
          new_entry_nxt.stamp = in_data.raise_time;
          idx_nxt             = '0;
          found_nxt           = 1'b0;
          list_n_nxt          = acc_n;
          case (in_data.req_type) inside
            REQ_RAISE, REQ_CLEAR: begin
              if (count_r != '0) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_nxt   = S_SCAN;
              end else begin
                state_nxt = S_DECIDE;
              end
            end
            default: begin
              // list, and the unused request code behaves as list
              if (acc_n != '0) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_nxt   = S_LIST;
              end else begin
                status_nxt = ST_LIST;
                state_nxt  = S_EMIT;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle; advance until match or end.
        if (ram_rd_data.code == new_entry_r.code) begin
          found_nxt     = 1'b1;
          found_lvl_nxt = ram_rd_data.level;
          state_nxt     = S_DECIDE;
        end else if (idx_p1 == cnt_ext1) begin
          state_nxt = S_DECIDE;
        end else begin
          ram_rd_en = 1'b1;
          idx_nxt   = idx_p1[IDX_W-1:0];
        end
      end

      S_DECIDE: begin
        state_nxt = S_EMIT;
        if (req_type_r == REQ_RAISE) begin
          if (found_r) begin
            status_nxt = ST_DUP;
          end else if (count_r < CNT_W'(MAX_ACTIVE)) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = count_r[IDX_W-1:0];
            ram_wr_data = new_entry_r;
            count_nxt   = count_r + CNT_W'(1);
            if (new_entry_r.level == LVL_CRIT) begin
              crit_cnt_nxt = crit_cnt_r + CNT_W'(1);
            end
            status_nxt = ST_ADDED;
          end else begin
            status_nxt = ST_FULL;
          end
        end else if (!found_r) begin
          status_nxt = ST_NOTFOUND;
        end else if (idx_p1 < cnt_ext1) begin
          // Close the gap: read the next entry, write it down next cycle.
          ram_rd_en = 1'b1;
          state_nxt = S_SHIFT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (found_lvl_r == LVL_CRIT) begin
            crit_cnt_nxt = crit_cnt_r - CNT_W'(1);
          end
          status_nxt = ST_CLEARED;
        end
      end

      S_SHIFT: begin
        ram_wr_en = 1'b1;
        if (idx_p2 < cnt_ext1) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_p2[IDX_W-1:0];
          idx_nxt     = idx_p1[IDX_W-1:0];
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (found_lvl_r == LVL_CRIT) begin
            crit_cnt_nxt = crit_cnt_r - CNT_W'(1);
          end
          status_nxt = ST_CLEARED;
          state_nxt  = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt               = '0;
          out_data_nxt.status        = status_r;
          out_data_nxt.last          = 1'b1;
          out_data_nxt.active_count  = 5'(count_r);
          out_data_nxt.any_critical  = (crit_cnt_r != '0);
          state_nxt                  = S_IDLE;
        end
      end

      S_LIST: begin
        // Hold the read data while the output is stalled.
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = ST_LIST;
          out_data_nxt.entry_valid  = 1'b1;
          out_data_nxt.entry_level  = ram_rd_data.level;
          out_data_nxt.entry_code   = 16'(ram_rd_data.code);
          out_data_nxt.entry_time   = ram_rd_data.stamp;
          out_data_nxt.last         = list_last;
          out_data_nxt.active_count = 5'(count_r);
          out_data_nxt.any_critical = (crit_cnt_r != '0);
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_rd_en = 1'b1;
            idx_nxt   = idx_p1[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      crit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      crit_cnt_r  <= crit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_type_r  <= req_type_nxt;
    new_entry_r <= new_entry_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    found_lvl_r <= found_lvl_nxt;
    status_r    <= status_nxt;
    list_n_r    <= list_n_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Critical alarms are a subset of the active ones.
  a_crit_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    crit_cnt_r <= count_r)
    else $error("critical count exceeds active count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ACTIVE))
    else $error("active count beyond table size");

  // One request at a time: an accepted beat closes the input until done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in work");

  // A beat that is not the last can only come from a list still in progress.
  a_mid_list_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> (state_r == S_LIST))
    else $error("non-final beat outside a list");

endmodule
